// ===== hdl/nipd_pkg.sv =====
package nipd_pkg;

   localparam logic [1:0] ACTION_EDGE = 2'd0;
   localparam logic [1:0] ACTION_TICK = 2'd1;
   localparam logic [1:0] ACTION_SCAN = 2'd2;

   localparam logic [15:0] ZERO_LO   = 16'd300;
   localparam logic [15:0] ZERO_HI   = 16'd800;
   localparam logic [15:0] ONE_LO    = 16'd1400;
   localparam logic [15:0] ONE_HI    = 16'd1800;
   localparam logic [15:0] REPEAT_LO = 16'd2200;
   localparam logic [15:0] REPEAT_HI = 16'd2600;
   localparam logic [15:0] LEADER_LO = 16'd4200;
   localparam logic [15:0] LEADER_HI = 16'd4700;

   localparam logic [3:0] OVF_LIMIT = 4'd14;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] pulse_time;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  key_code;
      logic [15:0] repeat_count;
      logic        next_polarity;
      logic        in_frame;
   } rsp_payload_type;

   function automatic logic in_band(input logic [15:0] t, input logic [15:0] lo,
                                    input logic [15:0] hi);
      in_band = (t > lo) && (t < hi);
   endfunction

endpackage

// ===== hdl/nipd_req_if.sv =====
interface nipd_req_if;
   logic                     valid;
   logic                     ready;
   nipd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/nipd_rsp_if.sv =====
interface nipd_rsp_if;
   logic                     valid;
   logic                     ready;
   nipd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/nec_ir_pulse_decoder.sv =====
// NEC IR pulse decoder.
// Each result is registered in a 2-entry output buffer that absorbs one stalled result.
// Throughput: 1 request per cycle while that buffer is not full (req ready drops when full).
// Reset: synchronous, active high; decoder state returns to idle, polarity expects rising.
module nec_ir_pulse_decoder (
   input  logic       clock,
   input  logic       reset,
   nipd_req_if.sink   req_chan,
   nipd_rsp_if.source rsp_chan
);
   import nipd_pkg::*;

   logic            take;
   logic            space;
   rsp_payload_type result;

   assign req_chan.ready = space;
   assign take           = req_chan.valid && space;

   nipd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_chan.payload),
      .rsp_data (result)
   );

   nipd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (result),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== hdl/nipd_core.sv =====
module nipd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  nipd_pkg::req_payload_type req_data,
   output nipd_pkg::rsp_payload_type rsp_data
);
   import nipd_pkg::*;

   logic        expect_rising_ff, expect_rising_in;
   logic        frame_active_ff, frame_active_in;
   logic        key_ready_ff, key_ready_in;
   logic        high_seen_ff, high_seen_in;
   logic [3:0]  overflow_count_ff, overflow_count_in;
   logic [31:0] code_shift_ff, code_shift_in;
   logic [15:0] repeats_ff, repeats_in;
   logic [7:0]  key;
   logic [7:0]  cmd;
   logic        key_valid;

   assign cmd       = code_shift_ff[15:8];
   assign key_valid = (code_shift_ff[31:24] == 8'h00) && (code_shift_ff[23:16] == 8'hFF)
                      && (cmd == ~code_shift_ff[7:0]);

   always_comb begin
      expect_rising_in  = expect_rising_ff;
      frame_active_in   = frame_active_ff;
      key_ready_in      = key_ready_ff;
      high_seen_in      = high_seen_ff;
      overflow_count_in = overflow_count_ff;
      code_shift_in     = code_shift_ff;
      repeats_in        = repeats_ff;
      key               = 8'h00;
      case (req_data.action)
         ACTION_EDGE: begin
            if (expect_rising_ff) begin
               expect_rising_in = 1'b0;
               high_seen_in     = 1'b1;
            end else begin
               expect_rising_in = 1'b1;
               high_seen_in     = 1'b0;
               if (high_seen_ff) begin
                  if (frame_active_ff) begin
                     if (in_band(req_data.pulse_time, ZERO_LO, ZERO_HI)) begin
                        code_shift_in = {code_shift_ff[30:0], 1'b0};
                     end else if (in_band(req_data.pulse_time, ONE_LO, ONE_HI)) begin
                        code_shift_in = {code_shift_ff[30:0], 1'b1};
                     end else if (in_band(req_data.pulse_time, REPEAT_LO, REPEAT_HI)) begin
                        repeats_in        = repeats_ff + 16'd1;
                        overflow_count_in = 4'd0;
                     end
                  end else if (in_band(req_data.pulse_time, LEADER_LO, LEADER_HI)) begin
                     frame_active_in = 1'b1;
                     repeats_in      = 16'd0;
                  end
               end
            end
         end
         ACTION_TICK: begin
            if (frame_active_ff) begin
               high_seen_in = 1'b0;
               if (overflow_count_ff != 4'd0) begin
                  key_ready_in = 1'b1;
               end
               if (overflow_count_ff < OVF_LIMIT) begin
                  overflow_count_in = overflow_count_ff + 4'd1;
               end else begin
                  frame_active_in   = 1'b0;
                  overflow_count_in = 4'd0;
               end
            end
         end
         ACTION_SCAN: begin
            if (key_ready_ff) begin
               key = key_valid ? cmd : 8'h00;
               if ((key == 8'h00) || !frame_active_ff) begin
                  key_ready_in = 1'b0;
                  repeats_in   = 16'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_data.key_code      = key;
   assign rsp_data.repeat_count  = repeats_in;
   assign rsp_data.next_polarity = expect_rising_in;
   assign rsp_data.in_frame      = frame_active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_rising_ff  <= 1'b1;
         frame_active_ff   <= 1'b0;
         key_ready_ff      <= 1'b0;
         high_seen_ff      <= 1'b0;
         overflow_count_ff <= 4'd0;
         code_shift_ff     <= 32'd0;
         repeats_ff        <= 16'd0;
      end else if (take) begin
         expect_rising_ff  <= expect_rising_in;
         frame_active_ff   <= frame_active_in;
         key_ready_ff      <= key_ready_in;
         high_seen_ff      <= high_seen_in;
         overflow_count_ff <= overflow_count_in;
         code_shift_ff     <= code_shift_in;
         repeats_ff        <= repeats_in;
      end
   end

endmodule

// ===== hdl/nipd_out_buf.sv =====
module nipd_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nipd_pkg::rsp_payload_type push_data,
   output logic                      space,
   nipd_rsp_if.source                rsp_chan
);
   import nipd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            pop;

   assign pop   = main_valid_ff && rsp_chan.ready;
   assign space = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid   = main_valid_ff;
   assign rsp_chan.payload = main_ff;

endmodule
